/* src/assert_macros.svh */
// Assertion helpers used by the checker file wth_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define WTH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wth assertion failed");

// Next-cycle implication checked outside reset.
`define WTH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wth assertion failed");

`endif

/* src/wth_pkg.sv */
// ----------------------------------------------------------------------------
// wth_pkg
// Shared types and constants of the weighted time histogram.
// ----------------------------------------------------------------------------
`default_nettype none
package wth_pkg;

  localparam int unsigned MAX_RECORDERS = 16;
  localparam int unsigned MAX_BINS      = 256;
  localparam int unsigned REC_W         = 4;
  localparam int unsigned BIN_W         = 8;
  localparam int unsigned ADDR_W        = $clog2(MAX_RECORDERS * MAX_BINS);
  localparam int unsigned DEPTH         = MAX_RECORDERS * MAX_BINS;

  typedef enum logic [1:0] {
    CFG_TIME_START = 2'd0,
    CFG_BIN_SCALE  = 2'd1,
    CFG_BINS_USED  = 2'd2,
    CFG_RECS_USED  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_ACC  = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DROPPED = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_CLS
  } front_state_e;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ,
    BS_UPDATE
  } back_state_e;

  typedef struct packed {
    logic [31:0]         time_start;
    logic [31:0]         bin_scale;
    logic [8:0]          bins_used;
    logic [4:0]          recs_used;
  } cfg_t;

  // Classified job handed from front to back.
  typedef struct packed {
    req_e                req;
    status_e             status;
    logic [BIN_W-1:0]    bin;
    logic [ADDR_W-1:0]   addr;
    logic [31:0]         weight;
    logic [63:0]         weight_sq;
    logic [63:0]         time_weight;
  } job_t;

  typedef struct packed {
    logic [31:0]         cnt;
    logic [63:0]         sw;
    logic [63:0]         sw2;
    logic [63:0]         stw;
  } sums_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } q_ctl_t;

endpackage
`default_nettype wire

/* src/wth_if.sv */
// ----------------------------------------------------------------------------
// wth_in_if / wth_out_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface wth_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  recorder;
  logic signed [31:0] arrival_time;
  logic [31:0] weight;
  logic [7:0]  read_bin;

  modport source (output valid, req_type, recorder, arrival_time, weight, read_bin,
                  input ready);
  modport sink   (input valid, req_type, recorder, arrival_time, weight, read_bin,
                  output ready);
endinterface

interface wth_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  bin_index;
  logic [31:0] hit_count;
  logic [63:0] sum_weight;
  logic [63:0] sum_weight_sq;
  logic signed [63:0] sum_time_weight;

  modport source (output valid, status, bin_index, hit_count, sum_weight, sum_weight_sq,
                  sum_time_weight, input ready);
  modport sink   (input valid, status, bin_index, hit_count, sum_weight, sum_weight_sq,
                  sum_time_weight, output ready);
endinterface
`default_nettype wire

/* src/wth_front.sv */
// ----------------------------------------------------------------------------
// wth_front
// Takes requests, computes products and bin, pushes classified jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module wth_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire wth_pkg::cfg_t cfg_i,
  wth_in_if.sink             in_req,
  input  wire logic          q_full_i,
  output wth_pkg::job_t      job_o,
  output logic               push_o
);

  wth_pkg::front_state_e state_q, state_d;

  logic                     req_q;
  logic [wth_pkg::REC_W-1:0] rec_q;
  logic signed [31:0]       t_q;
  logic [31:0]              w_q;
  logic [wth_pkg::BIN_W-1:0] rbin_q;
  logic signed [32:0]       d_q;
  logic                     neg_q;
  logic [64:0]              prod_q;
  logic [63:0]              wsq_q;
  logic [63:0]              tw_q;

  logic [32:0]              mag;
  logic signed [64:0]       tw_full;
  logic [48:0]              scaled;
  logic [8:0]               nb;
  logic [4:0]               nr;
  logic                     accept;

  assign accept = in_req.valid && in_req.ready;
  assign mag    = d_q[32] ? 33'(-d_q) : 33'(d_q);
  assign tw_full = $signed({t_q[31], t_q}) * $signed({1'b0, w_q});
  assign scaled = prod_q[64:16];
  assign nb     = (cfg_i.bins_used > 9'(wth_pkg::MAX_BINS)) ? 9'(wth_pkg::MAX_BINS)
                                                            : cfg_i.bins_used;
  assign nr     = (cfg_i.recs_used > 5'(wth_pkg::MAX_RECORDERS))
                  ? 5'(wth_pkg::MAX_RECORDERS) : cfg_i.recs_used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wth_pkg::FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_req.req_type;
      rec_q  <= in_req.recorder;
      t_q    <= in_req.arrival_time;
      w_q    <= in_req.weight;
      rbin_q <= in_req.read_bin;
      d_q    <= $signed({in_req.arrival_time[31], in_req.arrival_time})
              - $signed({cfg_i.time_start[31], cfg_i.time_start});
    end
    if (state_q == wth_pkg::FS_MUL) begin
      neg_q  <= d_q[32];
      prod_q <= mag * cfg_i.bin_scale;
      wsq_q  <= w_q * w_q;
      tw_q   <= tw_full[63:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    in_req.ready = 1'b0;
    push_o       = 1'b0;
    unique case (state_q)
      wth_pkg::FS_IDLE: begin
        in_req.ready = en_i;
        if (accept) state_d = wth_pkg::FS_MUL;
      end
      wth_pkg::FS_MUL: begin
        state_d = wth_pkg::FS_CLS;
      end
      wth_pkg::FS_CLS: begin
        if (!q_full_i) begin
          push_o  = 1'b1;
          state_d = wth_pkg::FS_IDLE;
        end
      end
      default: state_d = wth_pkg::FS_IDLE;
    endcase
  end

  // Classification of the captured request.
  always_comb begin
    job_o.req         = wth_pkg::req_e'(req_q);
    job_o.status      = wth_pkg::ST_DONE;
    job_o.bin         = '0;
    job_o.weight      = w_q;
    job_o.weight_sq   = wsq_q;
    job_o.time_weight = tw_q;
    if ({1'b0, rec_q} >= nr) begin
      job_o.status = wth_pkg::ST_INVALID;
      if (req_q == wth_pkg::REQ_READ) job_o.bin = rbin_q;
    end else if (req_q == wth_pkg::REQ_READ) begin
      job_o.bin = rbin_q;
      if ({1'b0, rbin_q} >= nb) job_o.status = wth_pkg::ST_INVALID;
    end else if ((neg_q && scaled != '0) || scaled >= 49'(nb)) begin
      job_o.status = wth_pkg::ST_DROPPED;
    end else begin
      job_o.bin = scaled[wth_pkg::BIN_W-1:0];
    end
    job_o.addr = {rec_q, job_o.bin};
  end

endmodule
`default_nettype wire

/* src/wth_queue.sv */
// ----------------------------------------------------------------------------
// wth_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module wth_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire wth_pkg::job_t job_i,
  input  wire logic          pop_i,
  output wth_pkg::job_t      job_o,
  output wth_pkg::q_ctl_t    ctl_o
);

  wth_pkg::job_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign job_o      = mem_q[rp_q];
  assign ctl_o.push = push_i;
  assign ctl_o.pop  = pop_i;
  assign ctl_o.full = (cnt_q == 2'd2);
  assign ctl_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

endmodule
`default_nettype wire

/* src/wth_back.sv */
// ----------------------------------------------------------------------------
// wth_back
// Table memory, read-modify-write of bin sums, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module wth_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire wth_pkg::job_t   job_i,
  input  wire wth_pkg::q_ctl_t q_i,
  output logic                 pop_o,
  output logic                 ready_o,
  wth_out_if.source            out_rsp
);

  wth_pkg::back_state_e state_q, state_d;

  wth_pkg::sums_t mem [wth_pkg::DEPTH];
  wth_pkg::sums_t rd_q;
  wth_pkg::job_t  cur_q;
  logic [wth_pkg::ADDR_W-1:0] clr_q;

  logic           out_vld_q;
  logic [1:0]     out_st_q;
  logic [7:0]     out_bin_q;
  wth_pkg::sums_t out_q;

  logic           mem_we;
  logic [wth_pkg::ADDR_W-1:0] mem_wa;
  wth_pkg::sums_t mem_wd;
  wth_pkg::sums_t upd, res;
  logic           slot_free, load;
  logic [64:0]    sw_s, sw2_s;
  logic [63:0]    stw_s;

  assign slot_free = !out_vld_q || out_rsp.ready;
  assign ready_o   = (state_q != wth_pkg::BS_CLEAR);

  // Saturating updates.
  always_comb begin
    sw_s    = {1'b0, rd_q.sw} + {33'b0, cur_q.weight};
    sw2_s   = {1'b0, rd_q.sw2} + {1'b0, cur_q.weight_sq};
    stw_s   = rd_q.stw + cur_q.time_weight;
    upd.cnt = (rd_q.cnt == '1) ? rd_q.cnt : rd_q.cnt + 32'd1;
    upd.sw  = sw_s[64] ? '1 : sw_s[63:0];
    upd.sw2 = sw2_s[64] ? '1 : sw2_s[63:0];
    if (rd_q.stw[63] == cur_q.time_weight[63] && stw_s[63] != rd_q.stw[63]) begin
      upd.stw = rd_q.stw[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      upd.stw = stw_s;
    end
    if (cur_q.status != wth_pkg::ST_DONE) res = '0;
    else if (cur_q.req == wth_pkg::REQ_READ) res = rd_q;
    else res = upd;
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = cur_q.addr;
    mem_wd  = upd;
    unique case (state_q)
      wth_pkg::BS_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        if (clr_q == '1) state_d = wth_pkg::BS_IDLE;
      end
      wth_pkg::BS_IDLE: begin
        if (!q_i.empty) begin
          pop_o = 1'b1;
          state_d = (job_i.status == wth_pkg::ST_DONE) ? wth_pkg::BS_READ
                                                       : wth_pkg::BS_UPDATE;
        end
      end
      wth_pkg::BS_READ: begin
        state_d = wth_pkg::BS_UPDATE;
      end
      wth_pkg::BS_UPDATE: begin
        if (slot_free) begin
          load    = 1'b1;
          mem_we  = (cur_q.status == wth_pkg::ST_DONE) && (cur_q.req == wth_pkg::REQ_ACC);
          state_d = wth_pkg::BS_IDLE;
        end
      end
      default: state_d = wth_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wth_pkg::BS_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == wth_pkg::BS_CLEAR) clr_q <= clr_q + 1'b1;
      if (load) out_vld_q <= 1'b1;
      else if (out_rsp.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= job_i;
    if (state_q == wth_pkg::BS_READ) rd_q <= mem[cur_q.addr];
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (load) begin
      out_st_q  <= cur_q.status;
      out_bin_q <= cur_q.bin;
      out_q     <= res;
    end
  end

  assign out_rsp.valid           = out_vld_q;
  assign out_rsp.status          = out_st_q;
  assign out_rsp.bin_index       = out_bin_q;
  assign out_rsp.hit_count       = out_q.cnt;
  assign out_rsp.sum_weight      = out_q.sw;
  assign out_rsp.sum_weight_sq   = out_q.sw2;
  assign out_rsp.sum_time_weight = out_q.stw;

endmodule
`default_nettype wire

/* src/weighted_time_histogram.sv */
// ----------------------------------------------------------------------------
// weighted_time_histogram
// Per-recorder weighted time-of-flight histogram with saturating bin sums.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps its 4096-entry table to zero, one entry
// per cycle, and in_req.ready stays low until the sweep is done. An accumulate
// request lands in bin trunc((t - time_start) * bin_scale / 2^16) of its
// recorder row and returns that bin's sums after the update; a read request
// returns one bin unchanged. The front captures and subtracts, multiplies and
// classifies each request; the back pops the job, reads the table (not for a
// dropped or invalid job), updates and, for an accumulate, writes back. A
// two-entry queue lets them overlap: the front takes a new request once it has
// pushed the last job, before the back is through with it.
// The user must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i
// only while no request is in flight; the block itself does not enforce it.
`default_nettype none
module weighted_time_histogram (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  wth_in_if.sink           in_req,
  wth_out_if.source        out_rsp,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  wth_pkg::cfg_t   cfg_q;
  wth_pkg::job_t   fr_job, q_job;
  wth_pkg::q_ctl_t q_ctl;
  logic            push, pop, back_ready;

  // Config registers, reset to full table and unit scale.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_start <= '0;
      cfg_q.bin_scale  <= 32'h0001_0000;
      cfg_q.bins_used  <= 9'd256;
      cfg_q.recs_used  <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (wth_pkg::cfg_idx_e'(cfg_idx_i))
        wth_pkg::CFG_TIME_START: cfg_q.time_start <= cfg_data_i;
        wth_pkg::CFG_BIN_SCALE:  cfg_q.bin_scale  <= cfg_data_i;
        wth_pkg::CFG_BINS_USED:  cfg_q.bins_used  <= cfg_data_i[8:0];
        wth_pkg::CFG_RECS_USED:  cfg_q.recs_used  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Front: accept, multiply, classify.
  wth_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (back_ready),
    .cfg_i    (cfg_q),
    .in_req   (in_req),
    .q_full_i (q_ctl.full),
    .job_o    (fr_job),
    .push_o   (push)
  );

  wth_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (fr_job),
    .pop_i  (pop),
    .job_o  (q_job),
    .ctl_o  (q_ctl)
  );

  // Back: table read-modify-write and result register.
  wth_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (q_job),
    .q_i     (q_ctl),
    .pop_o   (pop),
    .ready_o (back_ready),
    .out_rsp (out_rsp)
  );

endmodule
`default_nettype wire

/* src/wth_checker.sv */
// ----------------------------------------------------------------------------
// wth_checker
// Port-level checks on the histogram result channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module wth_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [7:0]  bin_index,
  input wire logic [31:0] hit_count,
  input wire logic [63:0] sum_weight,
  input wire logic [63:0] sum_weight_sq,
  input wire logic [63:0] sum_time_weight
);

  `WTH_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(status))
  `WTH_ASSERT_IMP(a_code, clk_i, rst_ni, out_valid, status != 2'd3)
  `WTH_ASSERT_IMP(a_zero, clk_i, rst_ni, out_valid && status != 2'd0, hit_count == '0 && sum_weight == '0 && sum_weight_sq == '0 && sum_time_weight == '0)
  `WTH_ASSERT_IMP(a_drop, clk_i, rst_ni, out_valid && status == 2'd1, bin_index == '0)
  `WTH_ASSERT_IMP(a_cnt, clk_i, rst_ni, out_valid && status == 2'd0 && hit_count == '0, sum_weight == '0 && sum_weight_sq == '0)

endmodule

bind weighted_time_histogram wth_checker u_wth_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .status          (out_rsp.status),
  .bin_index       (out_rsp.bin_index),
  .hit_count       (out_rsp.hit_count),
  .sum_weight      (out_rsp.sum_weight),
  .sum_weight_sq   (out_rsp.sum_weight_sq),
  .sum_time_weight (out_rsp.sum_time_weight)
);
`default_nettype wire
